// File: hw/rtl/tlg_pkg.sv
// Package for the toroidal life generation core: operation codes, sequencer
// states, pixel constants and the minimum grid size. No dependencies.
`timescale 1ns / 1ps
package tlg_pkg;
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_NB,
        ST_GEN,
        ST_OUT
    } t_state;

    localparam logic [7:0] PIX_LIVE = 8'd210;
    localparam logic [7:0] PIX_DEAD = 8'd3;
    localparam int unsigned MIN_SIZE = 3;
endpackage

// File: hw/rtl/tlg_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tlg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/toroidal_life_generation_core.sv
// Top level of the toroidal life generation core.
// Depends on tlg_pkg and tlg_ram.
`timescale 1ns / 1ps
// Square wrapped Game of Life grid (B3/S23) held in two bit-wide RAMs.
// Input word (s_axis): operation, row, col, alive_in. Each input word gives
// exactly one output word (m_axis): cell_alive, neighbour_count, pixel_value.
// Write cell: a write state, then reads of the cell and its 8 neighbours
// through the registered read port, then the output state; read cell skips
// the write; unused code or out-of-grid address goes straight to the output
// state, result all zero.
// Generation step: one RAM (the active bank) is read as a snapshot and the new
// cell is written into the other bank, which then becomes active. A cell in
// the N by N square reads itself and its 8 neighbours through the single read
// port; a cell outside it, in the M by M scan with M = MAX_SIZE, is copied
// across from its self read.
// After reset both banks are cleared by a pass over all 2^(2*clog2(MAX_SIZE))
// addresses (MAX_SIZE*MAX_SIZE for a power of two) during which no input word is
// accepted; grid size writes are taken anytime but belong between words.
// Words are handled one at a time. The output is a register: when the
// receiver stalls the result holds and no new word is accepted until it is
// taken; the next word can be accepted in the cycle after that.
module toroidal_life_generation_core
    import tlg_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [7:2] row, [13:8] col, [14] alive_in
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] cell_alive, [4:1] neighbour_count, [12:5] pixel_value
    output logic [15:0] m_axis_tdata
);
    localparam int AW    = $clog2(MAX_SIZE);
    localparam int DW    = 2 * AW;
    localparam int DEPTH = 1 << DW;
    localparam logic [6:0] SZ_MAX = 7'(MAX_SIZE > 127 ? 127 : MAX_SIZE);

    t_state r_state, n_state;
    logic [6:0]    r_size;
    logic          r_bank;
    logic [AW-1:0] r_row, r_col;
    logic          r_alive;
    logic [3:0]    r_k;       // read slot 0..9
    logic [3:0]    r_cnt;
    logic          r_self;
    logic [DW:0]   r_clr;
    logic          r_ovld;
    logic [12:0]   r_odata;

    // memory ports
    logic          we0, we1, wd;
    logic [DW-1:0] waddr, raddr;
    logic          rd0, rd1, rd;

    tlg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bank0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wd),
        .i_raddr(raddr), .o_rdata(rd0));
    tlg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bank1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wd),
        .i_raddr(raddr), .o_rdata(rd1));
    assign rd = r_bank ? rd1 : rd0;

    // incoming word fields
    logic [1:0] in_op;
    logic [5:0] in_row, in_col;
    logic       in_oob;
    assign in_op  = s_axis_tdata[1:0];
    assign in_row = s_axis_tdata[7:2];
    assign in_col = s_axis_tdata[13:8];
    assign in_oob = ({1'b0, in_row} >= r_size) || ({1'b0, in_col} >= r_size);

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovld;
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // wrapped neighbour addresses
    logic [AW-1:0] nmax, up, dn, lf, rt, ar, ac;
    logic          wrap_ok;
    assign nmax = AW'(r_size - 7'd1);
    assign up = (r_row == '0) ? nmax : r_row - AW'(1);
    assign dn = (r_row == nmax) ? '0 : r_row + AW'(1);
    assign lf = (r_col == '0) ? nmax : r_col - AW'(1);
    assign rt = (r_col == nmax) ? '0 : r_col + AW'(1);
    // a cell outside the active square is only copied during a generation
    assign wrap_ok = ({1'b0, r_row} < {1'b0, nmax} + 1'b1)
                  && ({1'b0, r_col} < {1'b0, nmax} + 1'b1)
                  && (AW'(r_row) <= nmax) && (AW'(r_col) <= nmax);

    // read address for slot k: 0 self, 1..8 neighbours
    always_comb begin
        ar = r_row;
        ac = r_col;
        case (r_k)
            4'd1: begin ar = up; ac = lf; end
            4'd2: begin ar = up; end
            4'd3: begin ar = up; ac = rt; end
            4'd4: begin ac = lf; end
            4'd5: begin ac = rt; end
            4'd6: begin ar = dn; ac = lf; end
            4'd7: begin ar = dn; end
            4'd8: begin ar = dn; ac = rt; end
            default: ;
        endcase
    end
    assign raddr = {ar, ac};

    logic rd_done;
    assign rd_done = (r_k == 4'd9) || (r_state == ST_GEN && !wrap_ok && r_k == 4'd1);

    logic [3:0] cnt_new;
    assign cnt_new = r_cnt + ((r_k >= 4'd2 && r_k <= 4'd9) ? {3'b0, rd} : 4'd0);

    logic gen_last;
    assign gen_last = (r_row == AW'(MAX_SIZE - 1)) && (r_col == AW'(MAX_SIZE - 1));

    logic nv;
    assign nv = r_self ? (cnt_new == 4'd2 || cnt_new == 4'd3) : (cnt_new == 4'd3);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == (DW+1)'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (acc) begin
                    if (t_op'(in_op) == OP_STEP) n_state = ST_GEN;
                    else if (t_op'(in_op) == OP_NONE || in_oob) n_state = ST_OUT;
                    else if (t_op'(in_op) == OP_WRITE) n_state = ST_WR;
                    else n_state = ST_NB;
                end
            end
            ST_WR:  n_state = ST_NB;
            ST_NB:  if (rd_done) n_state = ST_OUT;
            ST_GEN: if (rd_done && gen_last) n_state = ST_OUT;
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory write control
    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        wd = 1'b0;
        waddr = {r_row, r_col};
        case (r_state)
            ST_CLEAR: begin
                we0 = 1'b1;
                we1 = 1'b1;
                waddr = r_clr[DW-1:0];
            end
            ST_WR: begin
                wd = r_alive;
                we0 = !r_bank;
                we1 = r_bank;
            end
            ST_GEN: begin
                if (rd_done) begin
                    // outside cells copy the self read that lands this cycle
                    wd = wrap_ok ? nv : rd;
                    we0 = r_bank;
                    we1 = !r_bank;
                end
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_size  <= SZ_MAX;
            r_bank  <= 1'b0;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_wdata < 7'(MIN_SIZE)) r_size <= 7'(MIN_SIZE);
                else if (i_cfg_wdata > SZ_MAX) r_size <= SZ_MAX;
                else r_size <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (acc && t_op'(in_op) == OP_STEP) begin
                        r_row <= '0;
                        r_col <= '0;
                    end else if (acc) begin
                        r_row <= AW'(in_row);
                        r_col <= AW'(in_col);
                    end
                    if (acc) begin
                        r_alive <= s_axis_tdata[14];
                        r_cnt   <= '0;
                        r_odata <= '0;
                    end
                end
                ST_NB, ST_GEN: begin
                    if (r_k == 4'd1) r_self <= rd;
                    if (rd_done) begin
                        r_k <= '0;
                        r_cnt <= '0;
                        if (r_state == ST_NB) begin
                            r_odata <= {r_self ? PIX_LIVE : PIX_DEAD, cnt_new, r_self};
                        end else if (gen_last) begin
                            r_bank <= !r_bank;
                            r_odata <= '0;
                        end else if (r_col == AW'(MAX_SIZE - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + AW'(1);
                        end else begin
                            r_col <= r_col + AW'(1);
                        end
                    end else begin
                        r_cnt <= cnt_new;
                        r_k <= r_k + 4'd1;
                    end
                end
                ST_OUT: r_ovld <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {3'b000, r_odata};
endmodule
